[rtl/dro_pkg.sv]
// Shared types and constants for the delta-R overlap removal block.
// No dependencies; imported by every module of the block.
package dro_pkg;

    localparam int ETA_W  = 11;
    localparam int PHI_W  = 10;
    localparam int DIST_W = 23;
    localparam int IN_W   = 24;
    localparam int OUT_W  = 8;

    localparam logic [DIST_W-1:0] THRESHOLD_RESET = 23'd2401;
    localparam logic [PHI_W-1:0]  PHI_HALF        = 10'd512;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_STORE = 2'd1,
        OP_TEST  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic clear;
        logic store;
        logic load_cand;
        logic scan_read;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic scan_last;
        logic pipe_busy;
        logic full;
        logic overflow;
        logic clean;
    } t_status;

endpackage

[rtl/delta_r_overlap_removal_top.sv]
// Top level of the delta-R overlap removal block: controller, datapath and
// the result output register. Depends on dro_pkg, dro_ctrl, dro_dpath.
//
// Input stream (s_axis): one 24-bit word per item, ops clear, store, test.
// Output stream (m_axis): one word per test item with is_clean and the
// sticky store_overflow flag. Clear and store items give no output word.
// Config: i_cfg_wr_en writes threshold_sq from i_cfg_wr_data; write only
// while idle. Reset value of threshold_sq is 2401.
// Clear and store items do not hold the input. A test holds off the next
// word until all N stored objects have been compared and its result is
// loaded: one store entry is read per cycle from a single memory read port
// and fed through a four-stage distance pipe (read, differences, squares,
// sum and compare). With an empty store a test skips the scan.
// The result sits in an output register; the block takes new items while
// it waits. A test that completes while the register is still held by a
// stalled receiver waits until that word leaves.
// Reset (synchronous, active low) empties the store, clears the overflow
// flag and the output valid and restores threshold_sq.
module delta_r_overlap_removal_top #(
    parameter int MAX_OBJECTS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // [1:0] operation, [12:2] eta, [22:13] phi, [23] cut_pass
    input  logic [dro_pkg::IN_W-1:0]     i_s_axis_tdata,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // [0] is_clean, [1] store_overflow, [7:2] zero
    output logic [dro_pkg::OUT_W-1:0]    o_m_axis_tdata,
    input  logic                         i_cfg_wr_en,
    input  logic [dro_pkg::DIST_W-1:0]   i_cfg_wr_data
);
    import dro_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_out_free;
    logic    r_out_valid;
    logic    r_out_clean;
    logic    r_out_ovf;

    assign w_out_free = !r_out_valid || i_m_axis_tready;

    dro_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .i_op       (t_op'(i_s_axis_tdata[1:0])),
        .i_out_free (w_out_free),
        .i_status   (w_status),
        .o_ready    (o_s_axis_tready),
        .o_cmd      (w_cmd)
    );

    dro_dpath #(
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_eta         (i_s_axis_tdata[12:2]),
        .i_phi         (i_s_axis_tdata[22:13]),
        .i_pass        (i_s_axis_tdata[23]),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_status      (w_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.emit) begin
            r_out_clean <= w_status.clean;
            r_out_ovf   <= w_status.overflow;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_ovf, r_out_clean};

    // a result is only loaded into a free output slot
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!r_out_valid || i_m_axis_tready))
        else $error("result loaded over a pending word");

    // overflow can only be set once the store is full
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.overflow |-> w_status.full)
        else $error("overflow flag set with room in the store");

    // no new item taken while distance compares are in flight
    a_idle_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !w_status.pipe_busy)
        else $error("input ready while compare pipe busy");

    // a store read is never issued on an empty store
    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.scan_read |-> !w_status.count_zero)
        else $error("store scanned while empty");

endmodule

[rtl/dro_ctrl.sv]
// Controller FSM: sequences clear, store and test items, scans the store.
// Depends on dro_pkg.
module dro_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  dro_pkg::t_op    i_op,
    input  logic            i_out_free,
    input  dro_pkg::t_status i_status,
    output logic            o_ready,
    output dro_pkg::t_cmd   o_cmd
);
    import dro_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid && i_op == OP_TEST) begin
                    n_state = i_status.count_zero ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.scan_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!i_status.pipe_busy && i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    unique case (i_op)
                        OP_CLEAR: o_cmd.clear     = 1'b1;
                        OP_STORE: o_cmd.store     = 1'b1;
                        OP_TEST:  o_cmd.load_cand = 1'b1;
                        default:  o_cmd           = '0;
                    endcase
                end
            end
            ST_SCAN: begin
                o_cmd.scan_read = 1'b1;
            end
            ST_FINISH: begin
                // wait for the compare pipe to drain and the output slot
                o_cmd.emit = !i_status.pipe_busy && i_out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

[rtl/dro_dpath.sv]
// Datapath: object store memory, count and overflow flag, candidate
// registers and the four-stage distance compare pipe. Depends on dro_pkg.
module dro_dpath #(
    parameter int MAX_OBJECTS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dro_pkg::t_cmd                 i_cmd,
    input  logic [dro_pkg::ETA_W-1:0]     i_eta,
    input  logic [dro_pkg::PHI_W-1:0]     i_phi,
    input  logic                          i_pass,
    input  logic                          i_cfg_wr_en,
    input  logic [dro_pkg::DIST_W-1:0]    i_cfg_wr_data,
    output dro_pkg::t_status              o_status
);
    import dro_pkg::*;

    localparam int CW = $clog2(MAX_OBJECTS + 1);
    localparam int IW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_OBJECTS);

    logic [ETA_W-1:0]  mem_eta [MAX_OBJECTS];
    logic [PHI_W-1:0]  mem_phi [MAX_OBJECTS];

    logic [DIST_W-1:0] r_threshold;
    logic [CW-1:0]     r_count;
    logic              r_overflow;
    logic [IW-1:0]     r_idx;
    logic [ETA_W-1:0]  r_cand_eta;
    logic [PHI_W-1:0]  r_cand_phi;
    logic              r_clean;

    logic              r_v1, r_v2, r_v3;
    logic [ETA_W-1:0]  r_rd_eta;
    logic [PHI_W-1:0]  r_rd_phi;
    logic [ETA_W-1:0]  r_adeta;
    logic [PHI_W-1:0]  r_dphi;
    logic [21:0]       r_sq_eta;
    logic [19:0]       r_sq_phi;

    logic              w_full;
    logic [ETA_W:0]    w_deta;
    logic [PHI_W-1:0]  w_dp;
    logic [DIST_W-1:0] w_dist;

    assign w_full = (r_count == CNT_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else if (i_cfg_wr_en) begin
            r_threshold <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_overflow <= 1'b0;
        end else if (i_cmd.clear) begin
            r_count    <= '0;
            r_overflow <= 1'b0;
        end else if (i_cmd.store && i_pass) begin
            if (w_full) begin
                r_overflow <= 1'b1;
            end else begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    // store memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.store && i_pass && !w_full) begin
            mem_eta[r_count[IW-1:0]] <= i_eta;
            mem_phi[r_count[IW-1:0]] <= i_phi;
        end
        r_rd_eta <= mem_eta[r_idx];
        r_rd_phi <= mem_phi[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_cand) begin
            r_idx <= '0;
        end else if (i_cmd.scan_read) begin
            r_idx <= r_idx + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.scan_read;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // stage 2: |deta| and shortest way round for dphi
    assign w_deta = {r_cand_eta[ETA_W-1], r_cand_eta} - {r_rd_eta[ETA_W-1], r_rd_eta};
    assign w_dp   = r_cand_phi - r_rd_phi;

    always_ff @(posedge i_clk) begin
        r_adeta  <= w_deta[ETA_W] ? ETA_W'(~w_deta + (ETA_W+1)'(1)) : w_deta[ETA_W-1:0];
        r_dphi   <= (w_dp > PHI_HALF) ? (~w_dp + PHI_W'(1)) : w_dp;
        r_sq_eta <= {11'd0, r_adeta} * {11'd0, r_adeta};
        r_sq_phi <= {10'd0, r_dphi} * {10'd0, r_dphi};
    end

    assign w_dist = {1'b0, r_sq_eta} + {3'd0, r_sq_phi};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_cand) begin
            r_cand_eta <= i_eta;
            r_cand_phi <= i_phi;
            r_clean    <= i_pass;
        end else if (r_v3 && (w_dist < r_threshold)) begin
            r_clean <= 1'b0;
        end
    end

    assign o_status.count_zero = (r_count == '0);
    assign o_status.scan_last  = (CW'(r_idx) == r_count - CW'(1));
    assign o_status.pipe_busy  = r_v1 | r_v2 | r_v3;
    assign o_status.full       = w_full;
    assign o_status.overflow   = r_overflow;
    assign o_status.clean      = r_clean;

endmodule
